// ----- rtl/rmfw_pkg.sv -----
`default_nettype none
package rmfw_pkg;

  localparam int WAIT_DEPTH = 16;
  localparam int TID_W      = 8;
  localparam int NEST_W     = 8;
  localparam int PTR_W      = $clog2(WAIT_DEPTH);
  localparam int FILL_W     = $clog2(WAIT_DEPTH + 1);
  localparam int ID_SPACE   = 1 << TID_W;
  localparam int COUNT_W    = 5;

  localparam logic [NEST_W-1:0] NEST_MAX = {NEST_W{1'b1}};

  typedef enum logic {
    CMD_ACQUIRE = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    ST_GRANTED         = 4'd0,
    ST_NESTED          = 4'd1,
    ST_QUEUED          = 4'd2,
    ST_STILL_HELD      = 4'd3,
    ST_FREED           = 4'd4,
    ST_HANDOFF         = 4'd5,
    ST_NOT_HOLDER      = 4'd6,
    ST_ALREADY_WAITING = 4'd7,
    ST_FULL            = 4'd8
  } status_t;

  typedef struct packed {
    logic             command;
    logic [TID_W-1:0] thread_id;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [TID_W-1:0]   owner_id;
    logic               owner_valid;
    logic [COUNT_W-1:0] waiting_count;
  } rsp_t;

  // Queue operation requested by the lock controller.
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [TID_W-1:0] push_id;
  } qcmd_t;

  // Queue state seen by the lock controller.
  typedef struct packed {
    logic              full;
    logic              empty;
    logic              waiting;
    logic [TID_W-1:0]  head_id;
    logic [FILL_W-1:0] fill;
  } qstat_t;

endpackage
`default_nettype wire

// ----- rtl/rmfw_queue.sv -----
`default_nettype none
module rmfw_queue (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire rmfw_pkg::qcmd_t          qcmd,
  input  wire logic [rmfw_pkg::TID_W-1:0] query_id,
  output rmfw_pkg::qstat_t              qstat
);
  import rmfw_pkg::*;

  logic [TID_W-1:0]    q_mem [WAIT_DEPTH];
  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [PTR_W-1:0]    tail_r, tail_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [ID_SPACE-1:0] mark_r, mark_nxt;
  logic [TID_W-1:0]    head_id;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == PTR_W'(WAIT_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign head_id = q_mem[head_r];

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    mark_nxt = mark_r;
    if (qcmd.push) begin
      tail_nxt                = next_slot(tail_r);
      fill_nxt                = fill_r + FILL_W'(1);
      mark_nxt[qcmd.push_id]  = 1'b1;
    end else if (qcmd.pop) begin
      head_nxt          = next_slot(head_r);
      fill_nxt          = fill_r - FILL_W'(1);
      mark_nxt[head_id] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
      mark_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
      mark_r <= mark_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (qcmd.push) begin
      q_mem[tail_r] <= qcmd.push_id;
    end
  end

  assign qstat.full    = (fill_r == FILL_W'(WAIT_DEPTH));
  assign qstat.empty   = (fill_r == '0);
  assign qstat.waiting = mark_r[query_id];
  assign qstat.head_id = head_id;
  assign qstat.fill    = fill_r;

endmodule
`default_nettype wire

// ----- rtl/rmfw_ctrl.sv -----
`default_nettype none
module rmfw_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             req_valid,
  input  wire rmfw_pkg::req_t   req,
  input  wire rmfw_pkg::qstat_t qstat,
  output rmfw_pkg::qcmd_t       qcmd,
  output rmfw_pkg::rsp_t        rsp
);
  import rmfw_pkg::*;

  logic              held_r, held_nxt;
  logic [TID_W-1:0]  holder_r, holder_nxt;
  logic [NEST_W-1:0] nest_r, nest_nxt;
  logic              hit;
  status_t           status;
  logic [FILL_W-1:0] fill_after;

  assign hit = held_r && (holder_r == req.thread_id);

  always_comb begin
    held_nxt     = held_r;
    holder_nxt   = holder_r;
    nest_nxt     = nest_r;
    qcmd.push    = 1'b0;
    qcmd.pop     = 1'b0;
    qcmd.push_id = req.thread_id;
    status       = ST_NOT_HOLDER;
    if (req.command == CMD_ACQUIRE) begin
      if (hit) begin
        if (nest_r == NEST_MAX) begin
          status = ST_FULL;
        end else begin
          nest_nxt = nest_r + NEST_W'(1);
          status   = ST_NESTED;
        end
      end else if (!held_r) begin
        held_nxt   = 1'b1;
        holder_nxt = req.thread_id;
        nest_nxt   = NEST_W'(1);
        status     = ST_GRANTED;
      end else if (qstat.waiting) begin
        status = ST_ALREADY_WAITING;
      end else if (qstat.full) begin
        status = ST_FULL;
      end else begin
        qcmd.push = req_valid;
        status    = ST_QUEUED;
      end
    end else begin
      if (!hit) begin
        status = ST_NOT_HOLDER;
      end else if (nest_r > NEST_W'(1)) begin
        nest_nxt = nest_r - NEST_W'(1);
        status   = ST_STILL_HELD;
      end else if (qstat.empty) begin
        held_nxt   = 1'b0;
        holder_nxt = '0;
        nest_nxt   = '0;
        status     = ST_FREED;
      end else begin
        // Ownership goes straight to the oldest waiter.
        qcmd.pop   = req_valid;
        holder_nxt = qstat.head_id;
        nest_nxt   = NEST_W'(1);
        status     = ST_HANDOFF;
      end
    end
  end

  always_comb begin
    fill_after = qstat.fill;
    if (qcmd.push) begin
      fill_after = qstat.fill + FILL_W'(1);
    end else if (qcmd.pop) begin
      fill_after = qstat.fill - FILL_W'(1);
    end
  end

  assign rsp.status        = status;
  assign rsp.owner_id      = held_nxt ? holder_nxt : '0;
  assign rsp.owner_valid   = held_nxt;
  assign rsp.waiting_count = COUNT_W'(fill_after);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= 1'b0;
      holder_r <= '0;
      nest_r   <= '0;
    end else if (req_valid) begin
      held_r   <= held_nxt;
      holder_r <= holder_nxt;
      nest_r   <= nest_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/recursive_mutex_fifo_waiters.sv -----
`default_nettype none
// A transaction accepted at a clock edge is captured in the input register; its result is then
// captured in the result register, which drives the out_ ports.
// Throughput: one transaction per cycle; busy stays low, so start may be held every cycle.
// The receiver cannot stall: each result is on the out_ ports for exactly one cycle.
// Synchronous active-low reset frees the lock and empties the wait queue and its marks.
module recursive_mutex_fifo_waiters (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire rmfw_pkg::req_t in_req,
  output logic                out_valid,
  output rmfw_pkg::rsp_t      out_rsp
);
  import rmfw_pkg::*;

  logic   req_valid_r;
  req_t   req_r;
  rsp_t   rsp;
  qcmd_t  qcmd;
  qstat_t qstat;
  logic   out_valid_r;
  rsp_t   out_rsp_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      req_valid_r <= start && !busy;
      out_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r <= in_req;
    end
    if (req_valid_r) begin
      out_rsp_r <= rsp;
    end
  end

  rmfw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid_r),
    .req       (req_r),
    .qstat     (qstat),
    .qcmd      (qcmd),
    .rsp       (rsp)
  );

  rmfw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .qcmd     (qcmd),
    .query_id (req_r.thread_id),
    .qstat    (qstat)
  );

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule
`default_nettype wire
